[hdl/kmpsm_pkg.sv]
// shared types and constants of the streaming pattern matcher
`timescale 1ns / 1ps

package kmpsm_pkg;

  // fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 5;
  localparam int unsigned WordW   = 64;
  localparam int unsigned StartW  = 16;
  localparam int unsigned IndexW  = 2;
  localparam int unsigned WordBytes = 8;

  // register indexes on the configuration channel
  typedef enum logic [IndexW-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } reg_index_t;

  // reset value of the pattern length register
  localparam logic [LenW-1:0] LenReset = 5'd1;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic             advance;    // an item is accepted this cycle
    logic             restart;    // the item opens a new text
    logic [ByteW-1:0] text_byte;  // the byte of the item
  } cell_ctl_t;

endpackage

[hdl/kmpsm_text_if.sv]
// text byte channel
`timescale 1ns / 1ps

interface kmpsm_text_if;
  logic                       valid;
  logic                       ready;
  logic [kmpsm_pkg::ByteW-1:0] text_byte;
  logic                       start_of_text;

  modport source (output valid, output text_byte, output start_of_text, input ready);
  modport sink   (input valid, input text_byte, input start_of_text, output ready);
endinterface

[hdl/kmpsm_result_if.sv]
// match result channel
`timescale 1ns / 1ps

interface kmpsm_result_if;
  logic                         valid;
  logic                         ready;
  logic                         match_found;
  logic [kmpsm_pkg::StartW-1:0] match_start;

  modport source (output valid, output match_found, output match_start, input ready);
  modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

[hdl/kmpsm_cfg_if.sv]
// configuration write channel
`timescale 1ns / 1ps

interface kmpsm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [kmpsm_pkg::IndexW-1:0] index;
  logic [kmpsm_pkg::WordW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/kmpsm_cell.sv]
// one matcher cell: a pattern byte and the flag of the prefix that ends at it
`timescale 1ns / 1ps

module kmpsm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  kmpsm_pkg::cell_ctl_t          ctl,
  input  logic [kmpsm_pkg::ByteW-1:0]   load_byte,
  input  logic                          load_last,
  input  logic                          reset_last,
  input  logic                          chain_in,
  output logic                          match,
  output logic                          hit
);

  logic [kmpsm_pkg::ByteW-1:0] pat_byte;
  logic                        is_last;
  logic [kmpsm_pkg::ByteW-1:0] cmp_byte;
  logic                        last_eff;
  logic                        match_next;

  // a new text compares against the freshly loaded byte
  always_comb begin
    cmp_byte   = ctl.restart ? load_byte : pat_byte;
    last_eff   = ctl.restart ? load_last : is_last;
    match_next = chain_in && (ctl.text_byte == cmp_byte);
    hit        = match_next && last_eff;
  end

  // flag moves on with every item, pattern byte reloads at text start
  always_ff @(posedge clk) begin
    if (rst) begin
      match    <= 1'b0;
      pat_byte <= '0;
      is_last  <= reset_last;
    end else if (ctl.advance) begin
      match <= match_next;
      if (ctl.restart) begin
        pat_byte <= load_byte;
        is_last  <= load_last;
      end
    end
  end

endmodule

[hdl/kmp_stream_matcher_top.sv]
// Streaming pattern matcher: finds every occurrence of a 1 to 16 byte pattern
// in a byte stream, overlapping ones included.
// Channels: text (valid/ready, text_byte, start_of_text) in, result
// (valid/ready, match_found, match_start) out, cfg (valid/ready, index, data)
// writes pattern_length (0), pattern_low_bytes (1), pattern_high_bytes (2);
// other indexes are dropped. cfg is always ready.
// A byte with start_of_text set loads the pattern registers into the cells
// and restarts the position count at 0 for that byte.
// Every text byte gives one result item, registered in the cycle after it is accepted.
// One byte per cycle unless stalled: a row of MAX_PATTERN cells, each comparing
// the byte against its pattern byte and passing its prefix flag to the next cell.
// match_start is the occurrence's first byte position (low 16 bits), 0 with
// no match; the position count saturates at all ones.
// The result sits in an output register; a new byte is taken whenever that
// register is empty or being emptied, so a stalled receiver stalls the text
// channel after one result.
// Reset (synchronous): no result pending, pattern length 1, pattern bytes 0,
// position 0.
`timescale 1ns / 1ps

module kmp_stream_matcher_top #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  kmpsm_text_if.sink     text,
  kmpsm_result_if.source result,
  kmpsm_cfg_if.sink      cfg
);

  localparam int unsigned LenW = kmpsm_pkg::LenW;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  // configuration registers
  logic [LenW-1:0]               pattern_length;
  logic [kmpsm_pkg::WordW-1:0]   pattern_low_bytes;
  logic [kmpsm_pkg::WordW-1:0]   pattern_high_bytes;

  // active length minus one, held for the text in progress
  logic [LenW-1:0]               act_len_m1;
  logic [POSITION_BITS-1:0]      byte_position;

  logic                          accept;
  kmpsm_pkg::cell_ctl_t          ctl;
  logic [LenW-1:0]               load_len_m1;
  logic [LenW-1:0]               len_m1_cur;
  logic [POSITION_BITS-1:0]      pos_cur;
  logic [POSITION_BITS-1:0]      pos_step;
  logic [POSITION_BITS-1:0]      start_pos;
  logic [MAX_PATTERN-1:0]        cell_match;
  logic [MAX_PATTERN-1:0]        cell_hit;
  logic [MAX_PATTERN-1:0]        chain;
  logic                          any_hit;

  logic                          out_valid;
  logic                          match_found;
  logic [kmpsm_pkg::StartW-1:0]  match_start;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= kmpsm_pkg::LenReset;
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        kmpsm_pkg::REG_PATTERN_LENGTH: pattern_length     <= cfg.data[LenW-1:0];
        kmpsm_pkg::REG_PATTERN_LOW:    pattern_low_bytes  <= cfg.data;
        kmpsm_pkg::REG_PATTERN_HIGH:   pattern_high_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  // input handshake and cell control
  assign text.ready = !out_valid || result.ready;
  assign accept     = text.valid && text.ready;

  always_comb begin
    ctl.advance   = accept;
    ctl.restart   = text.start_of_text;
    ctl.text_byte = text.text_byte;
  end

  // clamp the length register into 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      load_len_m1 = '0;
    end else if (pattern_length > MaxLen) begin
      load_len_m1 = MaxLen - LenW'(1);
    end else begin
      load_len_m1 = pattern_length - LenW'(1);
    end
  end

  // row of cells
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    localparam int unsigned WordSel = k / kmpsm_pkg::WordBytes;
    localparam int unsigned ByteSel = k % kmpsm_pkg::WordBytes;
    logic [kmpsm_pkg::ByteW-1:0] load_byte;

    if (WordSel == 0) begin : g_low
      assign load_byte = pattern_low_bytes[ByteSel*kmpsm_pkg::ByteW +: kmpsm_pkg::ByteW];
    end else begin : g_high
      assign load_byte = pattern_high_bytes[ByteSel*kmpsm_pkg::ByteW +: kmpsm_pkg::ByteW];
    end

    // empty prefix always matches; a new text drops all longer prefixes
    if (k == 0) begin : g_head
      assign chain[k] = 1'b1;
    end else begin : g_link
      assign chain[k] = cell_match[k-1] && !ctl.restart;
    end

    kmpsm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .load_byte  (load_byte),
      .load_last  (load_len_m1 == LenW'(k)),
      .reset_last (k == 0),
      .chain_in   (chain[k]),
      .match      (cell_match[k]),
      .hit        (cell_hit[k])
    );
  end

  assign any_hit = |cell_hit;

  // position of this byte and start of a completed occurrence
  always_comb begin
    len_m1_cur = ctl.restart ? load_len_m1 : act_len_m1;
    pos_cur    = ctl.restart ? '0 : byte_position;
    pos_step   = (pos_cur < PosMax) ? pos_cur + POSITION_BITS'(1) : pos_cur;
    if (pos_cur < POSITION_BITS'(len_m1_cur)) begin
      start_pos = '0;
    end else begin
      start_pos = pos_cur - POSITION_BITS'(len_m1_cur);
    end
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      act_len_m1    <= '0;
      byte_position <= '0;
    end else if (accept) begin
      act_len_m1    <= len_m1_cur;
      byte_position <= pos_step;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      match_found <= 1'b0;
      match_start <= '0;
    end else if (accept) begin
      out_valid   <= 1'b1;
      match_found <= any_hit;
      match_start <= any_hit ? kmpsm_pkg::StartW'(start_pos) : '0;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.match_found = match_found;
  assign result.match_start = match_start;

endmodule

[sim/kmp_stream_matcher_checker.sv]
// scoreboard for the streaming pattern matcher: predicts each match result and compares
`timescale 1ns / 1ps

module kmp_stream_matcher_checker (
  input  logic    clk,
  input  logic    rst,
  kmpsm_text_if   text,
  kmpsm_result_if result,
  kmpsm_cfg_if    cfg,
  output int      failures,
  output int      pending
);

  localparam int unsigned ByteW  = kmpsm_pkg::ByteW;
  localparam int unsigned LenW   = kmpsm_pkg::LenW;
  localparam int unsigned WordW  = kmpsm_pkg::WordW;
  localparam int unsigned StartW = kmpsm_pkg::StartW;
  localparam int unsigned PatMax = 16;
  localparam logic [StartW-1:0] PosMax = '1;
  localparam int ReportMax = 10;

  typedef struct packed {
    logic              found;
    logic [StartW-1:0] start;
  } match_t;

  // register copies as last written on the config channel
  logic [LenW-1:0]  len_reg;
  logic [WordW-1:0] low_reg;
  logic [WordW-1:0] high_reg;

  // pattern, border table and scan state of the current text
  logic [ByteW-1:0] pat [PatMax];
  logic [LenW-1:0]  border [PatMax];
  int unsigned      pat_len;
  int unsigned      prefix_len;
  logic [StartW-1:0] position;

  match_t expected_matches[$];
  int     n_fail;

  function automatic void clear_state();
    int i;
    len_reg  = kmpsm_pkg::LenReset;
    low_reg  = '0;
    high_reg = '0;
    for (i = 0; i < PatMax; i++) begin
      pat[i]    = '0;
      border[i] = '0;
    end
    pat_len    = 1;
    prefix_len = 0;
    position   = '0;
    expected_matches.delete();
  endfunction

  // latch the pattern registers and build the longest proper border of each prefix
  function automatic void take_pattern();
    int unsigned m;
    int unsigned i;
    int unsigned k;
    m = 32'(len_reg);
    if (m < 1) m = 1;
    if (m > PatMax) m = PatMax;
    pat_len = m;
    for (i = 0; i < PatMax; i++) begin
      pat[i]    = (i < 8) ? low_reg[8*i +: 8] : high_reg[8*(i-8) +: 8];
      border[i] = '0;
    end
    k = 0;
    i = 1;
    while (i < m) begin
      if (pat[i] == pat[k]) begin
        k++;
        border[i] = LenW'(k);
        i++;
      end else if (k != 0) begin
        k = 32'(border[k-1]);
      end else begin
        border[i] = '0;
        i++;
      end
    end
  endfunction

  // advance the scan by one text byte and give the match it produces
  function automatic match_t next_match(logic [ByteW-1:0] c, logic sot);
    match_t      r;
    int unsigned j;
    if (sot) begin
      take_pattern();
      prefix_len = 0;
      position   = '0;
    end
    j = prefix_len;
    if (j >= pat_len) j = 0;
    while (j > 0 && pat[j] != c) j = 32'(border[j-1]);
    if (pat[j] == c) j++;
    r = '0;
    if (j >= pat_len) begin
      r.found = 1'b1;
      r.start = (position < pat_len - 1) ? '0 : StartW'(position - (pat_len - 1));
      j = 32'(border[pat_len-1]);
    end
    prefix_len = j;
    if (position != PosMax) position++;
    return r;
  endfunction

  function automatic void note_mismatch(string what, match_t want, match_t got);
    n_fail++;
    if (n_fail <= ReportMax)
      $display("%0t: %s: expected found=%0b start=%0d, got found=%0b start=%0d",
               $realtime, what, want.found, want.start, got.found, got.start);
  endfunction

  // results first, then new text items, then register writes
  always @(posedge clk) begin
    match_t want;
    match_t got;
    match_t fresh;
    if (rst) begin
      clear_state();
    end else begin
      if (result.valid && result.ready) begin
        got.found = result.match_found;
        got.start = result.match_start;
        if (expected_matches.size() == 0) begin
          note_mismatch("result with no item waiting", '0, got);
        end else begin
          want = expected_matches.pop_front();
          if (got !== want) note_mismatch("match mismatch", want, got);
        end
      end
      if (text.valid && text.ready) begin
        fresh = next_match(text.text_byte, text.start_of_text);
        expected_matches.insert(expected_matches.size(), fresh);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          kmpsm_pkg::REG_PATTERN_LENGTH: len_reg = cfg.data[LenW-1:0];
          kmpsm_pkg::REG_PATTERN_LOW:    low_reg = cfg.data;
          kmpsm_pkg::REG_PATTERN_HIGH:   high_reg = cfg.data;
          default: ;
        endcase
      end
    end
    failures <= n_fail;
    pending  <= expected_matches.size();
  end

endmodule

[sim/kmp_stream_matcher_top_tb.sv]
// testbench top for the streaming pattern matcher: stimulus, idling and verdict
`timescale 1ns / 1ps

module kmp_stream_matcher_top_tb;

  localparam int unsigned ByteW  = kmpsm_pkg::ByteW;
  localparam int unsigned LenW   = kmpsm_pkg::LenW;
  localparam int unsigned WordW  = kmpsm_pkg::WordW;
  localparam int unsigned IndexW = kmpsm_pkg::IndexW;

  // index past the end of the register list, writes to it are dropped
  localparam logic [IndexW-1:0] REG_NONE = 2'd3;
  localparam int unsigned CycleLimit    = 100_000;
  localparam int unsigned LongBytes     = 200;
  localparam int unsigned RandomBytes   = 800;

  logic clk;
  logic rst;

  kmpsm_text_if   text ();
  kmpsm_result_if result ();
  kmpsm_cfg_if    cfg ();

  int failures;
  int pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          bursty = 1'b0;
  int unsigned rx_mode = 0;
  int unsigned rx_tick = 0;

  kmp_stream_matcher_top dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .result (result),
    .cfg    (cfg)
  );

  kmp_stream_matcher_checker match_check (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .result   (result),
    .cfg      (cfg),
    .failures (failures),
    .pending  (pending)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern, switching to a randomly chosen style
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0: result.ready <= 1'b1;
      1: result.ready <= 1'($urandom_range(0, 1));
      2: result.ready <= (rx_tick % 7) >= 3;
      default: result.ready <= (rx_tick % 5) == 0;
    endcase
    if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 3);
  end

  // valid stays up so writes go back to back; set_pattern drops it
  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [WordW-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic set_pattern(input logic [WordW-1:0] len, input logic [WordW-1:0] low,
                             input logic [WordW-1:0] high);
    write_reg(kmpsm_pkg::REG_PATTERN_LENGTH, len);
    write_reg(kmpsm_pkg::REG_PATTERN_LOW, low);
    write_reg(kmpsm_pkg::REG_PATTERN_HIGH, high);
    cfg.valid <= 1'b0;
  endtask

  // one text item, with a random gap at the end of each burst
  task automatic put_byte(input logic [ByteW-1:0] b, input logic s);
    if (bursty && burst_left == 0) begin
      text.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    text.valid         <= 1'b1;
    text.text_byte     <= b;
    text.start_of_text <= s;
    do @(posedge clk); while (!text.ready);
    if (burst_left > 0) burst_left--;
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drained();
    text.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned i;
    int unsigned m;
    int unsigned k;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] bb;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] pb [16];
    logic [WordW-1:0] low;
    logic [WordW-1:0] high;
    logic [WordW-1:0] len;
    logic s;

    rst                = 1'b1;
    text.valid         = 1'b0;
    text.text_byte     = '0;
    text.start_of_text = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = '0;
    cfg.data           = '0;
    result.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pattern (one zero byte) before any text start
    put_byte(8'h00, 1'b0);
    put_byte(8'h41, 1'b0);
    put_byte(8'h00, 1'b0);

    // new registers do not apply until a text start
    wait_drained();
    set_pattern(64'd3, 64'h0000_0000_0041_4241, 64'hFFFF_FFFF_FFFF_FFFF);
    put_byte(8'h00, 1'b0);
    // overlapping occurrences of ABA
    put_byte(8'h41, 1'b1);
    put_byte(8'h42, 1'b0);
    put_byte(8'h41, 1'b0);
    put_byte(8'h42, 1'b0);
    put_byte(8'h41, 1'b0);

    // dropped index, zero length taken as one
    wait_drained();
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    set_pattern(64'd0, 64'h0000_0000_0000_00FF, 64'h0);
    put_byte(8'hFF, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);

    // oversize length taken as sixteen, all ones pattern
    wait_drained();
    set_pattern(64'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    for (i = 0; i < 17; i++) put_byte(8'hFF, i == 0);

    // one long text of A and B bytes without a restart
    wait_drained();
    set_pattern(64'd3, 64'h0000_0000_0041_4241, 64'h0);
    for (i = 0; i < LongBytes; i++)
      put_byte($urandom_range(0, 1) ? 8'h41 : 8'h42, i == 0);

    // random phases: two-letter patterns, texts built mostly from pattern copies
    sent = 0;
    while (sent < RandomBytes) begin
      wait_drained();
      bursty = $urandom_range(0, 3) != 0;
      a  = 8'($urandom_range(0, 255));
      bb = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0:       len = 64'd16;
        1:       len = {$urandom, $urandom};
        default: len = 64'($urandom_range(1, 6));
      endcase
      for (i = 0; i < 16; i++) pb[i] = $urandom_range(0, 1) ? a : bb;
      for (i = 0; i < 8; i++) begin
        low[8*i +: 8]  = pb[i];
        high[8*i +: 8] = pb[i+8];
      end
      if ($urandom_range(0, 4) == 0) write_reg(REG_NONE, {$urandom, $urandom});
      set_pattern(len, low, high);
      m = 32'(len[LenW-1:0]);
      if (m < 1) m = 1;
      if (m > 16) m = 16;
      n = $urandom_range(20, 150);
      k = 0;
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) < 17) begin
          b = pb[k];
          k = (k + 1 == m) ? 0 : k + 1;
        end else if ($urandom_range(0, 3) != 0) begin
          b = $urandom_range(0, 1) ? a : bb;
          k = 0;
        end else begin
          b = 8'($urandom_range(0, 255));
          k = 0;
        end
        s = (i == 0) || ($urandom_range(0, 49) == 0);
        put_byte(b, s);
      end
      sent += n;
    end

    // drain and settle, then verdict
    wait_drained();
    repeat (4) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[kmp_stream_matcher_top.f]
hdl/kmpsm_pkg.sv
hdl/kmpsm_text_if.sv
hdl/kmpsm_result_if.sv
hdl/kmpsm_cfg_if.sv
hdl/kmpsm_cell.sv
hdl/kmp_stream_matcher_top.sv
sim/kmp_stream_matcher_checker.sv
sim/kmp_stream_matcher_top_tb.sv
